@@ sv/dgcc_pkg.sv @@
// shared constants, codes and state type for the directed graph cycle check unit
// no dependencies; imported by the interfaces, dgcc_cfg and the top level
package dgcc_pkg;

    localparam int NODE_W   = 8;     // node field width on the item channel
    localparam int OPC_W    = 2;
    localparam int STAT_W   = 3;
    localparam int HELD_W   = 11;
    localparam int CFG_W    = 9;     // node_count register width
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam int DEF_MAX_NODES = 256;
    localparam int DEF_MAX_EDGES = 1024;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd256;

    localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OPC_W-1:0] OP_CHECK = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_CYCLE = 3'd3;
    localparam logic [STAT_W-1:0] ST_CYCLE    = 3'd4;

    typedef enum logic [3:0] {
        S_HCLR,
        S_IDLE,
        S_ADD,
        S_VCLR,
        S_ROOT,
        S_ROOTW,
        S_TOP,
        S_POP,
        S_EDGE,
        S_CHILD,
        S_SCAN,
        S_SCANE,
        S_SCANU,
        S_SCANV,
        S_DONE
    } t_state;

endpackage

@@ sv/dgcc_if.sv @@
// item and result channel interfaces (valid/ready with payload)
// depends on dgcc_pkg
interface dgcc_in_if;
    import dgcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;

    modport source (output valid, opcode, source_node, target_node, input ready);
    modport sink   (input valid, opcode, source_node, target_node, output ready);
endinterface

interface dgcc_out_if;
    import dgcc_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [HELD_W-1:0] edges_held;

    modport source (output valid, status, edges_held, input ready);
    modport sink   (input valid, status, edges_held, output ready);
endinterface

@@ sv/dgcc_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module dgcc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/dgcc_cfg.sv @@
// apb-style configuration port holding the node_count register
// depends on dgcc_pkg
module dgcc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dgcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dgcc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dgcc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [dgcc_pkg::CFG_W-1:0]    o_node_count
);
    import dgcc_pkg::*;

    logic [CFG_W-1:0] r_node_count;
    logic             w_wr;

    // single word register, the byte offset bits are not decoded
    assign w_wr   = psel & penable & pwrite & (paddr[PADDR_W-1:0] == paddr);
    assign pready = 1'b1;
    assign prdata = PDATA_W'(r_node_count);
    assign o_node_count = r_node_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (w_wr) begin
            r_node_count <= pwdata[CFG_W-1:0];
        end
    end
endmodule

@@ sv/directed_graph_cycle_check_unit.sv @@
// top level of the directed graph cycle check unit: sequencer, edge/node/stack rams
// depends on dgcc_pkg, dgcc_if, dgcc_ram, dgcc_cfg
//
// Loads directed edges one beat at a time into an edge ram that keeps a linked
// adjacency list per source node, and on a check beat runs an iterative depth
// first walk from node 0 upwards with an explicit stack ram, stamping pre and
// post times, then scans every stored edge for a back edge (inclusive test, so
// a self-loop is a cycle). Every input beat yields exactly one result beat.
// Sequence: after reset a clearing pass empties the list heads and no beat is
// taken meanwhile. An add writes the edge and its new list head; a clear runs
// the same head sweep. A check first clears the visited marks, then tries each
// root, pops and follows edges in the walk, then reads every stored edge in
// the scan; every step is bound by the single read port of the rams.
// A result waits in an output register until taken, the next beat is taken
// as soon as the sequencer is back at rest.
module directed_graph_cycle_check_unit #(
    parameter int MAX_NODES = dgcc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = dgcc_pkg::DEF_MAX_EDGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dgcc_in_if.sink                       i_item,
    dgcc_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dgcc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dgcc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dgcc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dgcc_pkg::*;

    // widths derived from the sizing parameters
    localparam int NW  = $clog2(MAX_NODES);          // node index
    localparam int CW  = $clog2(MAX_NODES + 1);      // node counts, stack depth
    localparam int XW  = (CW > CFG_W) ? CW : CFG_W;  // node compare width
    localparam int EW  = $clog2(MAX_EDGES + 1);      // edge pointer incl. empty code
    localparam int EAW = $clog2(MAX_EDGES);          // edge ram address
    localparam int TW  = $clog2(2 * MAX_NODES + 1);  // time stamps
    localparam int ERW = 2 * NW + EW;                // edge ram word {src, tgt, next}

    localparam logic [EW-1:0] EMPTY    = EW'(MAX_EDGES);
    localparam logic [CW-1:0] LAST_NOD = CW'(MAX_NODES - 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  w_node_count;
    logic [XW-1:0]     w_n;

    logic              r_init,    n_init;
    logic [CW-1:0]     r_cnt,     n_cnt;
    logic [EW-1:0]     r_total,   n_total;
    logic [NODE_W-1:0] r_src,     n_src;
    logic [NODE_W-1:0] r_dst,     n_dst;
    logic [TW-1:0]     r_time,    n_time;
    logic [CW-1:0]     r_depth,   n_depth;
    logic [NW-1:0]     r_top_node, n_top_node;
    logic [EW-1:0]     r_top_edge, n_top_edge;
    logic [NW-1:0]     r_child,   n_child;
    logic [EW-1:0]     r_scan,    n_scan;
    logic [TW-1:0]     r_pre_u,   n_pre_u;
    logic [TW-1:0]     r_post_u,  n_post_u;
    logic [STAT_W-1:0] r_res,     n_res;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [HELD_W-1:0] r_out_held,   n_out_held;

    // ram ports
    logic            w_e_we;
    logic [EAW-1:0]  w_e_waddr, w_e_raddr;
    logic [ERW-1:0]  w_e_wdata, w_e_rdata;
    logic            w_h_we;
    logic [NW-1:0]   w_h_waddr, w_h_raddr;
    logic [EW-1:0]   w_h_wdata, w_h_rdata;
    logic            w_p_we;
    logic [NW-1:0]   w_p_waddr, w_p_raddr;
    logic [TW:0]     w_p_wdata, w_p_rdata;     // {visited, pre time}
    logic            w_q_we;
    logic [NW-1:0]   w_q_waddr, w_q_raddr;
    logic [TW-1:0]   w_q_wdata, w_q_rdata;     // post time
    logic            w_s_we;
    logic [NW-1:0]   w_s_waddr, w_s_raddr;
    logic [NW+EW-1:0] w_s_wdata, w_s_rdata;    // {node, next edge}

    // fields of the edge word just read
    logic [NW-1:0]   w_e_src, w_e_tgt;
    logic [EW-1:0]   w_e_nxt;
    logic            w_out_free;
    logic            w_acc;

    assign {w_e_src, w_e_tgt, w_e_nxt} = w_e_rdata;

    // effective node count: register value clamped to the node capacity
    assign w_n = (XW'(w_node_count) > XW'(MAX_NODES)) ? XW'(MAX_NODES)
                                                      : XW'(w_node_count);

    assign w_out_free = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_acc = i_item.valid && (r_state == S_IDLE);

    assign o_result.valid      = r_out_valid;
    assign o_result.status     = r_out_status;
    assign o_result.edges_held = r_out_held;

    dgcc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_node_count (w_node_count)
    );

    // edge store with per-source next links
    dgcc_ram #(.W(ERW), .D(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(w_e_we), .i_waddr(w_e_waddr), .i_wdata(w_e_wdata),
        .i_raddr(w_e_raddr), .o_rdata(w_e_rdata)
    );

    // adjacency list heads
    dgcc_ram #(.W(EW), .D(MAX_NODES)) u_head_ram (
        .i_clk(i_clk), .i_we(w_h_we), .i_waddr(w_h_waddr), .i_wdata(w_h_wdata),
        .i_raddr(w_h_raddr), .o_rdata(w_h_rdata)
    );

    // visited mark with pre time
    dgcc_ram #(.W(TW + 1), .D(MAX_NODES)) u_pre_ram (
        .i_clk(i_clk), .i_we(w_p_we), .i_waddr(w_p_waddr), .i_wdata(w_p_wdata),
        .i_raddr(w_p_raddr), .o_rdata(w_p_rdata)
    );

    // post time
    dgcc_ram #(.W(TW), .D(MAX_NODES)) u_post_ram (
        .i_clk(i_clk), .i_we(w_q_we), .i_waddr(w_q_waddr), .i_wdata(w_q_wdata),
        .i_raddr(w_q_raddr), .o_rdata(w_q_rdata)
    );

    // walk stack, frames below the top one (the top frame lives in registers)
    dgcc_ram #(.W(NW + EW), .D(MAX_NODES)) u_stack_ram (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_waddr), .i_wdata(w_s_wdata),
        .i_raddr(w_s_raddr), .o_rdata(w_s_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_HCLR: begin
                if (r_cnt == LAST_NOD) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    case (i_item.opcode)
                        OP_ADD:   n_state = S_ADD;
                        OP_CHECK: n_state = S_VCLR;
                        OP_CLEAR: n_state = S_HCLR;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_ADD:   n_state = S_DONE;
            S_VCLR: begin
                if (r_cnt == LAST_NOD) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT:  n_state = (XW'(r_cnt) >= w_n) ? S_SCAN : S_ROOTW;
            S_ROOTW: n_state = w_p_rdata[TW] ? S_ROOT : S_TOP;
            S_TOP: begin
                if (r_top_edge >= r_total) begin
                    n_state = (r_depth == '0) ? S_ROOT : S_POP;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_POP:   n_state = S_TOP;
            S_EDGE:  n_state = (XW'(w_e_tgt) < w_n) ? S_CHILD : S_TOP;
            S_CHILD: n_state = S_TOP;
            S_SCAN:  n_state = (r_scan >= r_total) ? S_DONE : S_SCANE;
            S_SCANE: begin
                if (XW'(w_e_src) >= w_n || XW'(w_e_tgt) >= w_n) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_SCANU;
                end
            end
            S_SCANU: n_state = S_SCANV;
            S_SCANV: begin
                if (w_p_rdata[TW-1:0] <= r_pre_u && w_q_rdata >= r_post_u) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers and ram controls
    always_comb begin
        n_init       = r_init;
        n_cnt        = r_cnt;
        n_total      = r_total;
        n_src        = r_src;
        n_dst        = r_dst;
        n_time       = r_time;
        n_depth      = r_depth;
        n_top_node   = r_top_node;
        n_top_edge   = r_top_edge;
        n_child      = r_child;
        n_scan       = r_scan;
        n_pre_u      = r_pre_u;
        n_post_u     = r_post_u;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_held   = r_out_held;
        n_out_valid  = r_out_valid && !o_result.ready;

        w_e_we = 1'b0; w_e_waddr = r_total[EAW-1:0]; w_e_wdata = '0; w_e_raddr = '0;
        w_h_we = 1'b0; w_h_waddr = r_cnt[NW-1:0];    w_h_wdata = EMPTY; w_h_raddr = '0;
        w_p_we = 1'b0; w_p_waddr = r_cnt[NW-1:0];    w_p_wdata = '0; w_p_raddr = '0;
        w_q_we = 1'b0; w_q_waddr = r_top_node;       w_q_wdata = r_time; w_q_raddr = '0;
        w_s_we = 1'b0; w_s_waddr = r_depth[NW-1:0];
        w_s_wdata = {r_top_node, r_top_edge};
        w_s_raddr = '0;

        case (r_state)
            S_HCLR: begin
                // empty every list head, one per cycle
                w_h_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_NOD) begin
                    n_init = 1'b0;
                    n_res  = ST_CLEARED;
                end
            end
            S_IDLE: begin
                // head of the source list is fetched while the beat is taken
                w_h_raddr = NW'(i_item.source_node);
                if (w_acc) begin
                    n_src = i_item.source_node;
                    n_dst = i_item.target_node;
                    n_cnt = '0;
                    n_res = ST_REJECTED;
                    if (i_item.opcode == OP_CLEAR) begin
                        n_total = '0;
                    end
                end
            end
            S_ADD: begin
                if (XW'(r_src) < w_n && XW'(r_dst) < w_n && r_total != EMPTY) begin
                    w_e_we    = 1'b1;
                    w_e_wdata = {NW'(r_src), NW'(r_dst), w_h_rdata};
                    w_h_we    = 1'b1;
                    w_h_waddr = NW'(r_src);
                    w_h_wdata = r_total;
                    n_total   = r_total + 1'b1;
                    n_res     = ST_STORED;
                end
            end
            S_VCLR: begin
                // drop the visited marks of the previous check
                w_p_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_NOD) begin
                    n_cnt   = '0;
                    n_time  = '0;
                    n_depth = '0;
                end
            end
            S_ROOT: begin
                w_p_raddr = r_cnt[NW-1:0];
                w_h_raddr = r_cnt[NW-1:0];
                n_scan    = '0;
            end
            S_ROOTW: begin
                if (w_p_rdata[TW]) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    // enter a new root
                    w_p_we     = 1'b1;
                    w_p_wdata  = {1'b1, r_time};
                    n_time     = r_time + 1'b1;
                    n_top_node = r_cnt[NW-1:0];
                    n_top_edge = w_h_rdata;
                end
            end
            S_TOP: begin
                if (r_top_edge >= r_total) begin
                    // list exhausted: stamp post time and pop
                    w_q_we    = 1'b1;
                    n_time    = r_time + 1'b1;
                    w_s_raddr = NW'(r_depth - 1'b1);
                    if (r_depth == '0) begin
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end else begin
                    w_e_raddr = r_top_edge[EAW-1:0];
                end
            end
            S_POP: begin
                {n_top_node, n_top_edge} = w_s_rdata;
            end
            S_EDGE: begin
                n_top_edge = w_e_nxt;
                n_child    = w_e_tgt;
                w_p_raddr  = w_e_tgt;
                w_h_raddr  = w_e_tgt;
            end
            S_CHILD: begin
                if (!w_p_rdata[TW]) begin
                    // push the current frame and descend
                    w_s_we     = 1'b1;
                    n_depth    = r_depth + 1'b1;
                    w_p_we     = 1'b1;
                    w_p_waddr  = r_child;
                    w_p_wdata  = {1'b1, r_time};
                    n_time     = r_time + 1'b1;
                    n_top_node = r_child;
                    n_top_edge = w_h_rdata;
                end
            end
            S_SCAN: begin
                w_e_raddr = r_scan[EAW-1:0];
                n_res     = ST_NO_CYCLE;
            end
            S_SCANE: begin
                n_child   = w_e_tgt;
                w_p_raddr = w_e_src;
                w_q_raddr = w_e_src;
                if (XW'(w_e_src) >= w_n || XW'(w_e_tgt) >= w_n) begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_SCANU: begin
                n_pre_u   = w_p_rdata[TW-1:0];
                n_post_u  = w_q_rdata;
                w_p_raddr = r_child;
                w_q_raddr = r_child;
            end
            S_SCANV: begin
                // back edge: target entered no later and left no earlier
                if (w_p_rdata[TW-1:0] <= r_pre_u && w_q_rdata >= r_post_u) begin
                    n_res = ST_CYCLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res;
                    n_out_held   = HELD_W'(r_total);
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HCLR;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_total     <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_time       <= n_time;
        r_top_node   <= n_top_node;
        r_top_edge   <= n_top_edge;
        r_child      <= n_child;
        r_scan       <= n_scan;
        r_pre_u      <= n_pre_u;
        r_post_u     <= n_post_u;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_held   <= n_out_held;
    end
endmodule

@@ bench/directed_graph_cycle_check_unit_test.sv @@
// self-checking bench for the directed graph cycle check unit: edge loads, clears and checks
// depends on dgcc_pkg, dgcc_if and the unit under test; stands alone otherwise
`timescale 1ns / 1ps

module directed_graph_cycle_check_unit_test;
    import dgcc_pkg::*;

    localparam int MAXN = DEF_MAX_NODES;
    localparam int MAXE = DEF_MAX_EDGES;
    localparam int NIL  = MAXE;              // empty-list code for a head
    localparam logic [PADDR_W-1:0] REG_NODE_COUNT = '0;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HELD_W-1:0] edges_held;
    } t_result;

    // one row of the directed table; expected result only where obvious
    typedef struct {
        logic [OPC_W-1:0]  op;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        bit                known;
        t_result           res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;

    dgcc_in_if  item_ch ();
    dgcc_out_if res_ch ();

    directed_graph_cycle_check_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (res_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------
    // predictor state: its own copy of the edge store and node count
    // ---------------------------------------------------------------
    int      node_limit;
    int      edge_src [MAXE];
    int      edge_dst [MAXE];
    int      edge_link[MAXE];
    int      list_head[MAXN];
    int      edge_total;
    t_result pending_results[$];
    int      fail_count;

    // stall and idle percentages, changed per phase
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off_cycles;        // long receiver hold-off, counted down below

    function automatic int live_nodes();
        return node_limit > MAXN ? MAXN : node_limit;
    endfunction

    function automatic void empty_graph();
        for (int i = 0; i < MAXN; i++) list_head[i] = NIL;
        edge_total = 0;
    endfunction

    function automatic void expect_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // depth-first walk with pre/post stamps, then inclusive back-edge scan
    function automatic bit graph_has_cycle();
        int n, stamp, depth, u, v, e;
        bit seen[MAXN];
        int pre_t[MAXN];
        int post_t[MAXN];
        int stk_node[MAXN];
        int stk_edge[MAXN];
        n = live_nodes();
        stamp = 0;
        depth = 0;
        for (int i = 0; i < MAXN; i++) begin
            seen[i] = 0;
            pre_t[i] = 0;
            post_t[i] = 0;
        end
        for (int s = 0; s < n; s++) begin
            if (seen[s]) continue;
            seen[s] = 1;
            pre_t[s] = stamp;
            stamp = stamp + 1;
            stk_node[depth] = s;
            stk_edge[depth] = list_head[s];
            depth++;
            while (depth > 0) begin
                e = stk_edge[depth-1];
                if (e >= MAXE || e >= edge_total) begin
                    post_t[stk_node[depth-1]] = stamp;
                    stamp = stamp + 1;
                    depth--;
                end else begin
                    v = edge_dst[e];
                    stk_edge[depth-1] = edge_link[e];
                    if (v < n && !seen[v]) begin
                        seen[v] = 1;
                        pre_t[v] = stamp;
                        stamp = stamp + 1;
                        if (depth < MAXN) begin
                            stk_node[depth] = v;
                            stk_edge[depth] = list_head[v];
                            depth++;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < edge_total; i++) begin
            u = edge_src[i];
            v = edge_dst[i];
            if (u >= n || v >= n) continue;
            if (pre_t[v] <= pre_t[u] && post_t[v] >= post_t[u]) return 1;
        end
        return 0;
    endfunction

    function automatic t_result predict_beat(logic [OPC_W-1:0] op,
                                             logic [NODE_W-1:0] src,
                                             logic [NODE_W-1:0] dst);
        t_result r;
        int n;
        n = live_nodes();
        r.status = ST_REJECTED;
        case (op)
            OP_ADD: begin
                if (src < n && dst < n && edge_total < MAXE) begin
                    edge_src[edge_total]  = int'(src);
                    edge_dst[edge_total]  = int'(dst);
                    edge_link[edge_total] = list_head[src];
                    list_head[src] = edge_total;
                    edge_total++;
                    r.status = ST_STORED;
                end
            end
            OP_CHECK: r.status = graph_has_cycle() ? ST_CYCLE : ST_NO_CYCLE;
            OP_CLEAR: begin
                empty_graph();
                r.status = ST_CLEARED;
            end
            default: ;
        endcase
        r.edges_held = edge_total[HELD_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // sender side: one beat offered, held until accepted
    // ---------------------------------------------------------------
    task automatic send_beat(logic [OPC_W-1:0] op, logic [NODE_W-1:0] src,
                             logic [NODE_W-1:0] dst, bit known, t_result want);
        t_result got;
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.opcode      <= op;
        item_ch.source_node <= src;
        item_ch.target_node <= dst;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        got = predict_beat(op, src, dst);
        if (known) begin
            // typed rows are checked as typed, the predictor must agree too
            if (got.status !== want.status) begin
                $error("predicted status: expected %0d actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.edges_held !== want.edges_held) begin
                $error("predicted edges_held: expected %0d actual %0d",
                       want.edges_held, got.edges_held);
                fail_count++;
            end
            expect_result(want);
        end else begin
            expect_result(got);
        end
    endtask

    task automatic send_random(logic [OPC_W-1:0] op);
        send_beat(op, NODE_W'($urandom_range(255)), NODE_W'($urandom_range(255)), 0, '0);
    endtask

    // random edge within the live range, mostly forward to build deep chains
    task automatic send_edge_in_range(bit forward_only);
        int n, a, b;
        n = live_nodes();
        if (n == 0) n = 1;
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        if (forward_only && a > b) begin
            int t;
            t = a; a = b; b = t;
        end
        if (forward_only && a == b && b < n - 1) b++;
        send_beat(OP_ADD, NODE_W'(a), NODE_W'(b), 0, '0);
    endtask

    // drop valid and wait until every expected result has come
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let the unit settle before the configuration port is touched
        repeat (8) @(posedge i_clk);
    endtask

    // apb write: setup then access, register written at the access edge
    task automatic write_node_count(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NODE_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_limit = value & 9'h1FF;
    endtask

    // ---------------------------------------------------------------
    // receiver side: random stalls, long hold-off, compare with oldest
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d held %0d",
                           res_ch.status, res_ch.edges_held);
                    fail_count++;
                end else begin
                    t_result want;
                    want = pending_results.pop_front();
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, res_ch.status);
                        fail_count++;
                    end
                    if (res_ch.edges_held !== want.edges_held) begin
                        $error("edges_held: expected %0d actual %0d",
                               want.edges_held, res_ch.edges_held);
                        fail_count++;
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // directed table: extremes, every opcode, each special case
    t_row dir_rows[$];

    function automatic t_row mk(logic [OPC_W-1:0] op, int s, int d,
                                bit known, logic [STAT_W-1:0] st, int held);
        t_row r;
        r.op = op; r.src = NODE_W'(s); r.dst = NODE_W'(d); r.known = known;
        r.res.status = st; r.res.edges_held = HELD_W'(held);
        return r;
    endfunction

    function automatic void add_row(t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    initial begin
        // check on an empty graph right after reset
        add_row(mk(OP_CHECK, 0, 0, 1, ST_NO_CYCLE, 0));
        add_row(mk(OP_ADD, 0, 255, 1, ST_STORED, 1));
        add_row(mk(OP_ADD, 255, 0, 1, ST_STORED, 2));
        add_row(mk(OP_CHECK, 0, 0, 1, ST_CYCLE, 2));
        add_row(mk(OP_CLEAR, 0, 0, 1, ST_CLEARED, 0));
        // self-loop counts as a cycle
        add_row(mk(OP_ADD, 7, 7, 1, ST_STORED, 1));
        add_row(mk(OP_CHECK, 255, 255, 1, ST_CYCLE, 1));
        add_row(mk(OP_CLEAR, 255, 255, 1, ST_CLEARED, 0));
        // chain without a cycle, then closed
        add_row(mk(OP_ADD, 1, 2, 0, ST_STORED, 0));
        add_row(mk(OP_ADD, 2, 3, 0, ST_STORED, 0));
        add_row(mk(OP_ADD, 1, 3, 0, ST_STORED, 0));
        add_row(mk(OP_CHECK, 0, 0, 0, ST_STORED, 0));
        add_row(mk(OP_ADD, 3, 1, 0, ST_STORED, 0));
        add_row(mk(OP_CHECK, 0, 0, 0, ST_STORED, 0));
        // unknown opcode changes nothing
        add_row(mk(2'd3, 170, 85, 1, ST_REJECTED, 4));
        add_row(mk(OP_CLEAR, 0, 0, 1, ST_CLEARED, 0));
        add_row(mk(OP_ADD, 85, 170, 0, ST_STORED, 0));
        add_row(mk(OP_CHECK, 0, 0, 0, ST_STORED, 0));
        add_row(mk(OP_CLEAR, 0, 0, 1, ST_CLEARED, 0));
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        t_row r;
        int budget;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_ADD;
        item_ch.source_node = '0;
        item_ch.target_node = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles <= 0;
        node_limit = NODE_COUNT_RST;
        empty_graph();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            send_beat(r.op, r.src, r.dst, r.known, r.res);
        end
        wait_drained();

        // node count extremes: zero rejects all, one gives a one-node graph
        write_node_count(0);
        send_beat(OP_ADD, 0, 0, 1, '{ST_REJECTED, 11'd0});
        send_beat(OP_CHECK, 0, 0, 1, '{ST_NO_CYCLE, 11'd0});
        wait_drained();
        write_node_count(1);
        send_beat(OP_ADD, 0, 1, 1, '{ST_REJECTED, 11'd0});
        send_beat(OP_ADD, 0, 0, 1, '{ST_STORED, 11'd1});
        send_beat(OP_CHECK, 0, 0, 1, '{ST_CYCLE, 11'd1});
        wait_drained();
        // above the node limit clamps to all nodes; lower after loading
        write_node_count(511);
        send_beat(OP_ADD, 200, 3, 0, '0);
        send_beat(OP_ADD, 3, 200, 0, '0);
        send_beat(OP_CHECK, 0, 0, 0, '0);
        wait_drained();
        write_node_count(100);
        send_beat(OP_CHECK, 0, 0, 0, '0);
        send_beat(OP_CLEAR, 0, 0, 1, '{ST_CLEARED, 11'd0});
        wait_drained();

        // random phases over several node counts and idle patterns
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            case (phase)
                0: write_node_count(8);
                1: write_node_count(2);
                2: write_node_count(256);
                3: write_node_count(16);
                4: write_node_count(40);
                5: write_node_count(300);
                6: write_node_count(4);
                default: write_node_count(64);
            endcase
            if (phase == 2) hold_off_cycles <= 3000;  // block fills and stalls input
            budget = 0;
            while (budget < 80) begin
                int pick;
                pick = $urandom_range(99);
                // build a forward graph, check, maybe close it and check, maybe clear
                if (pick < 70) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_edge_in_range(1);
                        budget++;
                    end
                    send_beat(OP_CHECK, NODE_W'($urandom_range(255)),
                              NODE_W'($urandom_range(255)), 0, '0);
                    budget++;
                    if ($urandom_range(1)) begin
                        send_edge_in_range(0);
                        send_beat(OP_CHECK, 0, 0, 0, '0);
                        budget += 2;
                    end
                    if ($urandom_range(3) == 0) begin
                        send_random(OP_CLEAR);
                        budget++;
                    end
                end else begin
                    send_random(OPC_W'($urandom_range(3)));
                    budget++;
                end
            end
            // sender pauses until every result is home, then resumes
            wait_drained();
            send_beat(OP_CLEAR, 0, 0, 0, '0);
            wait_drained();
        end

        if (fail_count == 0)
            $display("directed_graph_cycle_check_unit test passed");
        else
            $display("directed_graph_cycle_check_unit test failed");
        $finish;
    end

    initial begin
        #10ms;
        $display("directed_graph_cycle_check_unit test failed");
        $finish;
    end

endmodule
